FILE: sv/tpaf_pkg.sv
package tpaf_pkg;

   localparam int NUM_CHANNELS_DEF = 2;
   localparam int TW = 16;
   localparam int LW = 17;
   localparam int CSR_IW = 2;

   localparam logic [TW-1:0] PERIOD_RESET = 16'd16667;
   localparam logic [LW-1:0] LEVEL_FULL = 17'h10000;

   localparam logic [TW-1:0] PULSE_WIDTH_RESET = 16'd200;
   localparam logic [TW-1:0] MIN_FALL_RESET = 16'd0;
   localparam logic [LW-1:0] FULL_ON_RESET = 17'd62259;
   localparam logic [LW-1:0] FULL_OFF_RESET = 17'd3277;

   localparam logic [CSR_IW-1:0] CSR_PULSE_WIDTH = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_MIN_FALL = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_FULL_ON = 2'd2;
   localparam logic [CSR_IW-1:0] CSR_FULL_OFF = 2'd3;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_SET = 1'b1;

   typedef struct packed {
      logic tick;
      logic zc;
      logic [TW-1:0] tb_new;
      logic [TW-1:0] cap_new;
      logic [TW-1:0] elapsed;
   } time_type;

   typedef struct packed {
      logic pin_on;
      logic pin_off;
      logic [TW-1:0] on_delay;
      logic [TW-1:0] off_delay;
   } set_type;

endpackage

FILE: sv/tpaf_delay_calc.sv
module tpaf_delay_calc import tpaf_pkg::*; (
   input  logic [LW-1:0] level,
   input  logic [TW-1:0] period,
   input  logic [TW-1:0] pulse_width,
   input  logic [TW-1:0] min_fall_time,
   input  logic [LW-1:0] full_on_level,
   input  logic [LW-1:0] full_off_level,
   output set_type       set_out
);

   logic [LW-1:0] lv;
   logic [LW-1:0] inv;
   logic [TW+LW-1:0] prod;
   logic [TW-1:0] up;
   logic [TW:0] s;
   logic [TW-1:0] dn;

   always_comb begin
      lv = (level > LEVEL_FULL) ? LEVEL_FULL : level;
      inv = LEVEL_FULL - lv;
      prod = {{LW{1'b0}}, period} * {{TW{1'b0}}, inv};
      up = prod[TW+TW-1:TW];
      s = {1'b0, up} + {1'b0, pulse_width};
      priority if (s < {1'b0, min_fall_time}) begin
         dn = min_fall_time;
      end else if (s > {1'b0, period}) begin
         dn = period;
      end else begin
         dn = s[TW-1:0];
      end
      set_out.pin_on = level > full_on_level;
      set_out.pin_off = level < full_off_level;
      set_out.on_delay = up;
      set_out.off_delay = dn;
   end

endmodule

FILE: sv/tpaf_channel.sv
module tpaf_channel import tpaf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  time_type tm,
   input  logic     sel,
   input  set_type  set_in,
   output logic     gate_in
);

   typedef enum logic [1:0] {PH_IDLE, PH_RISE, PH_FALL, PH_DONE} phase_type;

   phase_type phase_ff, phase_in, ph0, ph1;
   logic [TW-1:0] on_ff, on_in, off_ff, off_in, lat_ff, lat_in, match_ff, match_in;
   logic [TW-1:0] m0, m1;
   logic en_ff, en_in, stat_ff, stat_in;

   always_comb begin
      ph0 = phase_ff;
      m0 = match_ff;
      lat_in = lat_ff;
      on_in = on_ff;
      off_in = off_ff;
      en_in = en_ff;
      stat_in = stat_ff;
      if (tm.tick && tm.zc) begin
         m0 = tm.tb_new + on_ff;
         lat_in = off_ff;
         ph0 = en_ff ? PH_RISE : PH_IDLE;
      end
      ph1 = ph0;
      m1 = m0;
      if (tm.tick && ph0 == PH_RISE && tm.elapsed >= TW'(m0 - tm.cap_new)) begin
         ph1 = PH_FALL;
         m1 = tm.cap_new + lat_in;
      end
      phase_in = ph1;
      if (tm.tick && ph1 == PH_FALL && tm.elapsed >= TW'(m1 - tm.cap_new)) begin
         phase_in = PH_DONE;
      end
      match_in = m1;
      if (sel) begin
         priority if (set_in.pin_on) begin
            stat_in = 1'b1;
            en_in = 1'b0;
            phase_in = PH_IDLE;
         end else if (set_in.pin_off) begin
            stat_in = 1'b0;
            en_in = 1'b0;
            phase_in = PH_IDLE;
         end else begin
            on_in = set_in.on_delay;
            off_in = set_in.off_delay;
            en_in = 1'b1;
         end
      end
      gate_in = (phase_in == PH_IDLE) ? stat_in : (phase_in == PH_FALL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         on_ff <= '0;
         off_ff <= '0;
         lat_ff <= '0;
         match_ff <= '0;
         en_ff <= 1'b0;
         stat_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         on_ff <= on_in;
         off_ff <= off_in;
         lat_ff <= lat_in;
         match_ff <= match_in;
         en_ff <= en_in;
         stat_ff <= stat_in;
      end
   end

endmodule

FILE: sv/triac_phase_angle_firing.sv
// Path: a req word is taken into the input register, then the state update
// and result register form the rsp word; a held rsp word stalls the step
// between the two.
// Throughput: one word per cycle; the rsp register drains while the
// next req word is taken, and a stalled rsp holds the req side.
// Reset: synchronous, active high; clears timebase, capture, channel
// state, config registers to defaults and period to 16667 ticks.
module triac_phase_angle_firing import tpaf_pkg::*; #(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,  // zero_cross, channel, level[16:0], zero pad
   input  logic              req_tuser,  // req_type
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,  // gate_a, gate_b, period_ticks[15:0], zero pad
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [LW-1:0]     csr_wdata
);

   logic in_valid_ff, in_type_ff, in_zc_ff, in_ch_ff;
   logic [LW-1:0] in_level_ff;
   logic out_valid_ff;
   logic gate_a_ff, gate_b_ff;
   logic [TW-1:0] out_period_ff;
   logic [TW-1:0] tb_ff, tb_in, cap_ff, cap_in, period_ff, period_in;
   logic [TW-1:0] pw_ff, minf_ff;
   logic [LW-1:0] fon_ff, foff_ff;
   logic advance, step;
   time_type tm;
   set_type set_w;
   logic [NUM_CHANNELS-1:0] gates_in;
   logic gate_b_in;

   assign advance = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign step = in_valid_ff && advance;

   always_comb begin
      tb_in = tb_ff;
      cap_in = cap_ff;
      period_in = period_ff;
      tm.tick = step && (in_type_ff == REQ_TICK);
      tm.zc = in_zc_ff;
      if (tm.tick) begin
         tb_in = tb_ff + 1'b1;
         if (in_zc_ff) begin
            period_in = tb_in - cap_ff;
            cap_in = tb_in;
         end
      end
      tm.tb_new = tb_in;
      tm.cap_new = cap_in;
      tm.elapsed = tb_in - cap_in;
   end

   tpaf_delay_calc u_calc (
      .level(in_level_ff),
      .period(period_ff),
      .pulse_width(pw_ff),
      .min_fall_time(minf_ff),
      .full_on_level(fon_ff),
      .full_off_level(foff_ff),
      .set_out(set_w)
   );

   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_ch
      tpaf_channel u_ch (
         .clock(clock),
         .reset(reset),
         .tm(tm),
         .sel(step && (in_type_ff == REQ_SET) && (int'(in_ch_ff) == c)),
         .set_in(set_w),
         .gate_in(gates_in[c])
      );
   end

   if (NUM_CHANNELS > 1) begin : g_gb
      assign gate_b_in = gates_in[1];
   end else begin : g_gb0
      assign gate_b_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         tb_ff <= '0;
         cap_ff <= '0;
         period_ff <= PERIOD_RESET;
         pw_ff <= PULSE_WIDTH_RESET;
         minf_ff <= MIN_FALL_RESET;
         fon_ff <= FULL_ON_RESET;
         foff_ff <= FULL_OFF_RESET;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         tb_ff <= tb_in;
         cap_ff <= cap_in;
         period_ff <= period_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_PULSE_WIDTH: pw_ff <= csr_wdata[TW-1:0];
               CSR_MIN_FALL:    minf_ff <= csr_wdata[TW-1:0];
               CSR_FULL_ON:     fon_ff <= csr_wdata;
               CSR_FULL_OFF:    foff_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      if (req_tready && req_tvalid) begin
         in_type_ff <= req_tuser;
         in_zc_ff <= req_tdata[0];
         in_ch_ff <= req_tdata[1];
         in_level_ff <= req_tdata[LW+1:2];
      end
      if (step) begin
         gate_a_ff <= gates_in[0];
         gate_b_ff <= gate_b_in;
         out_period_ff <= period_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {6'd0, out_period_ff, gate_b_ff, gate_a_ff};

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && out_valid_ff && !rsp_tready)
      else $error("req stalled without a held rsp word");

   a_tb_step: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && $past(step) && $past(in_type_ff) == REQ_TICK
      |-> tb_ff == TW'($past(tb_ff) + 1'b1))
      else $error("timebase did not advance on tick");

   a_tb_hold: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && !($past(step) && $past(in_type_ff) == REQ_TICK)
      |-> $stable(tb_ff))
      else $error("timebase moved without tick");

   a_period_zc: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && period_ff != $past(period_ff)
      |-> $past(step) && $past(in_type_ff) == REQ_TICK && $past(in_zc_ff))
      else $error("period changed without zero cross");

endmodule
